### hdl/plcr_pkg.sv
// Package for the piecewise linear color ramp: widths, register map, reset
// values and the item structs passed between pipeline stages.
// No dependencies.
`default_nettype none

package plcr_pkg;

    localparam int MAX_POINTS_DEF = 7;
    localparam int REG_POINTS     = 7;

    localparam int LEVEL_W = 16;
    localparam int CHAN_W  = 8;
    localparam int NCHAN   = 3;
    localparam int PROD_W  = CHAN_W + LEVEL_W;
    localparam int QUO_W   = CHAN_W;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = LEVEL_W + NCHAN * CHAN_W;

    // register map
    localparam logic [IDX_W-1:0] REG_COUNT   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_POINT_0 = IDX_W'(1);

    localparam logic [CNT_W-1:0] COUNT_RST  = CNT_W'(2);
    localparam logic [CFG_W-1:0] POINT0_RST = 40'h00_0000_00DB;
    localparam logic [CFG_W-1:0] POINT1_RST = 40'h64_00E6_E2DB;

    // channel order inside the packed arrays
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic [LEVEL_W-1:0] pos;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } t_point;

    typedef struct packed {
        logic [NCHAN-1:0][CHAN_W-1:0] base;
        logic [NCHAN-1:0][CHAN_W-1:0] mag;
        logic [NCHAN-1:0]             neg;
        logic [LEVEL_W-1:0]           num;
        logic [LEVEL_W-1:0]           den;
    } t_prep;

    typedef struct packed {
        logic [NCHAN-1:0][CHAN_W-1:0] base;
        logic [NCHAN-1:0]             neg;
        logic [LEVEL_W-1:0]           den;
        logic [NCHAN-1:0][PROD_W-1:0] rem;
        logic [NCHAN-1:0][QUO_W-1:0]  quo;
    } t_quo;

endpackage

`default_nettype wire

### hdl/piecewise_linear_color_ramp_core.sv
// Top level of the piecewise linear color ramp: configuration registers and
// the select, multiply, divide and blend pipeline. Depends on plcr_pkg and
// plcr_select, plcr_mult, plcr_div, plcr_blend.
//
//   channel   direction  handshake                        payload
//   level     in         i_level_valid / o_level_ready    i_level[15:0]
//   color     out        o_color_valid / i_color_ready    o_red, o_green, o_blue
//   config    in         i_cfg_we (no wait)               i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; 12 register
// stages: two select stages, one multiply, eight divider stages (one quotient
// bit each), one output stage.
// The divider depth is set by the 8-bit quotient.
// Synchronous active-low reset clears all stage valids and loads the default
// ramp. Each stage holds its item while the one after it is full and stalled.
`default_nettype none

module piecewise_linear_color_ramp_core #(
    parameter int MAX_POINTS = plcr_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [plcr_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [plcr_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_level_valid,
    output logic                               o_level_ready,
    input  wire logic [plcr_pkg::LEVEL_W-1:0]  i_level,
    output logic                               o_color_valid,
    input  wire logic                          i_color_ready,
    output logic [plcr_pkg::CHAN_W-1:0]        o_red,
    output logic [plcr_pkg::CHAN_W-1:0]        o_green,
    output logic [plcr_pkg::CHAN_W-1:0]        o_blue
);
    import plcr_pkg::*;

    logic [CNT_W-1:0]           r_count;
    t_point [REG_POINTS-1:0]    r_points;

    logic   w_sel_vld;
    logic   w_mul_rdy;
    t_prep  w_prep;
    logic   w_mul_vld;
    logic   w_div_rdy;
    t_quo   w_mul_q;
    logic   w_div_vld;
    logic   w_bld_rdy;
    t_quo   w_div_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RST;
            for (int i = 0; i < REG_POINTS; i++) begin
                if (i == 0) begin
                    r_points[i] <= t_point'(POINT0_RST);
                end else if (i == 1) begin
                    r_points[i] <= t_point'(POINT1_RST);
                end else begin
                    r_points[i] <= '0;
                end
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_COUNT) begin
                r_count <= i_cfg_data[CNT_W-1:0];
            end else begin
                r_points[i_cfg_index - REG_POINT_0] <= t_point'(i_cfg_data);
            end
        end
    end

    plcr_select #(
        .MAX_POINTS (MAX_POINTS)
    ) u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_count  (r_count),
        .i_points (r_points),
        .i_vld    (i_level_valid),
        .o_rdy    (o_level_ready),
        .i_level  (i_level),
        .o_vld    (w_sel_vld),
        .i_rdy    (w_mul_rdy),
        .o_prep   (w_prep)
    );

    plcr_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_sel_vld),
        .o_rdy   (w_mul_rdy),
        .i_prep  (w_prep),
        .o_vld   (w_mul_vld),
        .i_rdy   (w_div_rdy),
        .o_quo   (w_mul_q)
    );

    plcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_mul_vld),
        .o_rdy   (w_div_rdy),
        .i_quo   (w_mul_q),
        .o_vld   (w_div_vld),
        .i_rdy   (w_bld_rdy),
        .o_quo   (w_div_q)
    );

    plcr_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_div_vld),
        .o_rdy   (w_bld_rdy),
        .i_quo   (w_div_q),
        .o_vld   (o_color_valid),
        .i_rdy   (i_color_ready),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

`ifndef SYNTH
    // an empty output stage frees the whole ready chain
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_color_valid |-> o_level_ready)
        else $error("input stalled with empty output stage");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_color_valid)
        else $error("result item valid right after reset");

    // a result item that is not taken stays put
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_color_valid && !i_color_ready) |=>
            (o_color_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue)))
        else $error("result item changed while stalled");
`endif

endmodule

`default_nettype wire

### hdl/plcr_select.sv
// Breakpoint search and interpolation set-up, two register stages.
// Depends on plcr_pkg.
`default_nettype none

module plcr_select #(
    parameter int MAX_POINTS = plcr_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic [plcr_pkg::CNT_W-1:0]                i_count,
    input  wire plcr_pkg::t_point [plcr_pkg::REG_POINTS-1:0] i_points,
    input  wire logic                                      i_vld,
    output logic                                           o_rdy,
    input  wire logic [plcr_pkg::LEVEL_W-1:0]              i_level,
    output logic                                           o_vld,
    input  wire logic                                      i_rdy,
    output plcr_pkg::t_prep                                o_prep
);
    import plcr_pkg::*;

    logic [CNT_W-1:0]   w_cnt;
    logic [CNT_W-1:0]   w_last;
    logic               w_found;
    logic [IDX_W-1:0]   w_sel;
    logic [IDX_W-1:0]   w_hi_idx;
    logic               w_interp;
    logic               w_rdy_a;
    logic               w_rdy_b;

    logic               r_a_vld;
    logic               r_a_interp;
    t_point             r_a_lo;
    t_point             r_a_hi;
    logic [LEVEL_W-1:0] r_a_level;

    logic [NCHAN-1:0][CHAN_W-1:0] w_lo_c;
    logic [NCHAN-1:0][CHAN_W-1:0] w_hi_c;
    t_prep              n_b;
    logic               r_b_vld;
    t_prep              r_b;

    assign w_rdy_b = !r_b_vld || i_rdy;
    assign w_rdy_a = !r_a_vld || w_rdy_b;
    assign o_rdy   = w_rdy_a;
    assign o_vld   = r_b_vld;
    assign o_prep  = r_b;

    // stage A: highest breakpoint at or below the level
    always_comb begin
        w_cnt = i_count;
        if (i_count == '0) begin
            w_cnt = CNT_W'(1);
        end else if (i_count > CNT_W'(MAX_POINTS)) begin
            w_cnt = CNT_W'(MAX_POINTS);
        end
        w_last  = w_cnt - CNT_W'(1);
        w_found = 1'b0;
        w_sel   = '0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            if (CNT_W'(i) < w_cnt && i_points[i].pos <= i_level) begin
                w_found = 1'b1;
                w_sel   = IDX_W'(i);
            end
        end
        w_interp = w_found && (w_sel != w_last);
        w_hi_idx = w_interp ? w_sel + IDX_W'(1) : w_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_rdy_a) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_vld) begin
            r_a_interp <= w_interp;
            r_a_lo     <= i_points[w_sel];
            r_a_hi     <= i_points[w_hi_idx];
            r_a_level  <= i_level;
        end
    end

    // stage B: offsets, span and per-channel color step
    always_comb begin
        w_lo_c[CH_RED]   = r_a_lo.red;
        w_lo_c[CH_GREEN] = r_a_lo.green;
        w_lo_c[CH_BLUE]  = r_a_lo.blue;
        w_hi_c[CH_RED]   = r_a_hi.red;
        w_hi_c[CH_GREEN] = r_a_hi.green;
        w_hi_c[CH_BLUE]  = r_a_hi.blue;
        n_b.base = w_lo_c;
        n_b.num  = r_a_level - r_a_lo.pos;
        // nonzero span keeps the divider quotient at zero for a plain color
        n_b.den  = r_a_interp ? r_a_hi.pos - r_a_lo.pos : LEVEL_W'(1);
        for (int c = 0; c < NCHAN; c++) begin
            if (!r_a_interp) begin
                n_b.mag[c] = '0;
                n_b.neg[c] = 1'b0;
            end else if (w_hi_c[c] >= w_lo_c[c]) begin
                n_b.mag[c] = w_hi_c[c] - w_lo_c[c];
                n_b.neg[c] = 1'b0;
            end else begin
                n_b.mag[c] = w_lo_c[c] - w_hi_c[c];
                n_b.neg[c] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_rdy_b) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_a_vld) begin
            r_b <= n_b;
        end
    end

endmodule

`default_nettype wire

### hdl/plcr_mult.sv
// Multiply stage: color step magnitude times level offset, per channel.
// Depends on plcr_pkg.
`default_nettype none

module plcr_mult (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    output logic                  o_rdy,
    input  wire plcr_pkg::t_prep  i_prep,
    output logic                  o_vld,
    input  wire logic             i_rdy,
    output plcr_pkg::t_quo        o_quo
);
    import plcr_pkg::*;

    logic   w_rdy;
    t_quo   n_q;
    logic   r_vld;
    t_quo   r_q;

    assign w_rdy = !r_vld || i_rdy;
    assign o_rdy = w_rdy;
    assign o_vld = r_vld;
    assign o_quo = r_q;

    always_comb begin
        n_q.base = i_prep.base;
        n_q.neg  = i_prep.neg;
        n_q.den  = i_prep.den;
        n_q.quo  = '0;
        for (int c = 0; c < NCHAN; c++) begin
            n_q.rem[c] = PROD_W'(i_prep.mag[c]) * PROD_W'(i_prep.num);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_vld) begin
            r_q <= n_q;
        end
    end

endmodule

`default_nettype wire

### hdl/plcr_div.sv
// Pipelined restoring divider, one quotient bit per stage, three channels
// side by side. Quotient is known to fit QUO_W bits. Depends on plcr_pkg.
`default_nettype none

module plcr_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_vld,
    output logic                 o_rdy,
    input  wire plcr_pkg::t_quo  i_quo,
    output logic                 o_vld,
    input  wire logic            i_rdy,
    output plcr_pkg::t_quo       o_quo
);
    import plcr_pkg::*;

    localparam int STEPS = QUO_W;

    t_quo   w_in   [STEPS];
    logic   w_vin  [STEPS];
    logic   w_down [STEPS];
    logic   w_rdy  [STEPS];
    t_quo   n_st   [STEPS];
    t_quo   r_st   [STEPS];
    logic   r_vld  [STEPS];

    assign w_in[0]  = i_quo;
    assign w_vin[0] = i_vld;
    assign o_rdy    = w_rdy[0];
    assign o_vld    = r_vld[STEPS-1];
    assign o_quo    = r_st[STEPS-1];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int BIT = STEPS - 1 - k;

        logic [PROD_W-1:0] w_dvs;

        if (k > 0) begin : g_link
            assign w_in[k]  = r_st[k-1];
            assign w_vin[k] = r_vld[k-1];
        end
        if (k < STEPS - 1) begin : g_mid
            assign w_down[k] = w_rdy[k+1];
        end else begin : g_end
            assign w_down[k] = i_rdy;
        end

        assign w_rdy[k] = !r_vld[k] || w_down[k];
        assign w_dvs    = PROD_W'(w_in[k].den) << BIT;

        always_comb begin
            n_st[k] = w_in[k];
            for (int c = 0; c < NCHAN; c++) begin
                if (w_in[k].rem[c] >= w_dvs) begin
                    n_st[k].rem[c]      = w_in[k].rem[c] - w_dvs;
                    n_st[k].quo[c][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= w_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_vin[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/plcr_blend.sv
// Output stage: applies the signed color step to the lower color and holds
// the result item until taken. Depends on plcr_pkg.
`default_nettype none

module plcr_blend (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_vld,
    output logic                              o_rdy,
    input  wire plcr_pkg::t_quo               i_quo,
    output logic                              o_vld,
    input  wire logic                         i_rdy,
    output logic [plcr_pkg::CHAN_W-1:0]       o_red,
    output logic [plcr_pkg::CHAN_W-1:0]       o_green,
    output logic [plcr_pkg::CHAN_W-1:0]       o_blue
);
    import plcr_pkg::*;

    logic                         w_rdy;
    logic [NCHAN-1:0][CHAN_W-1:0] n_res;
    logic                         r_vld;
    logic [NCHAN-1:0][CHAN_W-1:0] r_res;

    assign w_rdy   = !r_vld || i_rdy;
    assign o_rdy   = w_rdy;
    assign o_vld   = r_vld;
    assign o_red   = r_res[CH_RED];
    assign o_green = r_res[CH_GREEN];
    assign o_blue  = r_res[CH_BLUE];

    // result stays between the two colors, no clamp needed
    always_comb begin
        for (int c = 0; c < NCHAN; c++) begin
            if (i_quo.neg[c]) begin
                n_res[c] = i_quo.base[c] - i_quo.quo[c];
            end else begin
                n_res[c] = i_quo.base[c] + i_quo.quo[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_vld) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire
